FILE: rtl/crc32k_fc_pkg.sv
// shared types, constants and crc update function for the crc-32k frame checker
`timescale 1ns / 1ps

package crc32k_fc_pkg;

  localparam logic [31:0] CrcPoly  = 32'h741B_8CD7;
  localparam logic [31:0] CrcInit  = 32'hFFFF_FFFF;
  localparam int unsigned SeenW    = 3;
  localparam logic [SeenW-1:0] MinFrame = SeenW'(5);
  localparam logic [SeenW-1:0] TailLen  = SeenW'(4);
  localparam int unsigned TailDepth = 4;

  // one input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } item_t;

  // one result request
  typedef struct packed {
    logic [31:0] crc_value;
    logic        crc_match;
    logic        too_short;
  } result_t;

  // byte into the low bits, then 32 msb-first shifts; flattens to an xor network
  function automatic logic [31:0] crc_feed(logic [31:0] crc_v, logic [7:0] b);
    logic [31:0] r;
    r = crc_v ^ {24'h0, b};
    for (int i = 0; i < 32; i++) begin
      r = r[31] ? ({r[30:0], 1'b0} ^ CrcPoly) : {r[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: rtl/crc32k_fc_core.sv
// frame state (running crc, trailer delay line, byte count) and result logic
`timescale 1ns / 1ps

module crc32k_fc_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   check_mode_i,
  input  crc32k_fc_pkg::item_t   item_i,
  output crc32k_fc_pkg::result_t result_o
);

  logic [31:0]                      crc_q, crc_d;
  logic [7:0]                       tail_q [crc32k_fc_pkg::TailDepth];
  logic [7:0]                       tail_d [crc32k_fc_pkg::TailDepth];
  logic [crc32k_fc_pkg::SeenW-1:0]  seen_q, seen_d;
  logic                             had_four;
  logic [31:0]                      crc_upd;
  logic [31:0]                      trailer;

  assign had_four = (seen_q >= crc32k_fc_pkg::TailLen);

  always_comb begin
    crc_upd = crc_q;
    if (check_mode_i) begin
      // oldest held byte enters the crc once four newer ones are behind it
      if (had_four) begin
        crc_upd = crc32k_fc_pkg::crc_feed(crc_q, tail_q[0]);
      end
    end else begin
      crc_upd = crc32k_fc_pkg::crc_feed(crc_q, item_i.data_byte);
    end
  end

  // trailer as seen after this byte shifts in, oldest byte most significant
  assign trailer = {tail_q[1], tail_q[2], tail_q[3], item_i.data_byte};

  always_comb begin
    result_o = '0;
    if (check_mode_i) begin
      if (!had_four) begin
        result_o.too_short = 1'b1;
      end else begin
        result_o.crc_value = crc_upd;
        result_o.crc_match = (trailer == crc_upd);
      end
    end else begin
      result_o.crc_value = crc_upd;
    end
  end

  always_comb begin
    crc_d  = crc_q;
    tail_d = tail_q;
    seen_d = seen_q;
    if (step_i) begin
      if (item_i.frame_end) begin
        crc_d  = crc32k_fc_pkg::CrcInit;
        tail_d = '{default: 8'h00};
        seen_d = '0;
      end else begin
        crc_d = crc_upd;
        if (check_mode_i) begin
          tail_d[0] = tail_q[1];
          tail_d[1] = tail_q[2];
          tail_d[2] = tail_q[3];
          tail_d[3] = item_i.data_byte;
        end
        if (seen_q < crc32k_fc_pkg::MinFrame) begin
          seen_d = seen_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= crc32k_fc_pkg::CrcInit;
      tail_q <= '{default: 8'h00};
      seen_q <= '0;
    end else begin
      crc_q  <= crc_d;
      tail_q <= tail_d;
      seen_q <= seen_d;
    end
  end

endmodule

FILE: rtl/crc32k_frame_checker.sv
// top level of the crc-32k frame checker: input register, core, result register
`timescale 1ns / 1ps

// crc-32k (poly 0x741B8CD7, init all ones, no reflection, no final xor) frame
// checker and generator.
// input stream: one frame byte per request on s_axis, tlast on the final byte.
// output stream: one result request per frame, on the cycle after the final
//   byte is processed; tdata carries the crc, tuser the match / too-short flags.
// config: cfg_we_i writes check_mode (1 = verify trailing big-endian crc,
//   0 = generate crc over all bytes); write only while no frame is in flight.
// path: an accepted byte waits in the input register until the core processes
//   it; a final byte's result is then captured in the result register and is
//   held on m_axis until its handshake.
// throughput: one byte per cycle while no final byte waits on a held result;
//   the crc xor network between the input and result registers is combinational.
// stall: mid-frame bytes never wait on m_axis; a final byte waits in the input
//   register only while the previous result is still held, so s_axis_tready_o
//   drops only while m_axis is stalled with a result pending.
// reset: check mode on, frame state cleared, both registers empty.

module crc32k_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,      // check_mode
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // frame_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] crc_value
  output logic [1:0]  m_axis_tuser_o    // [0] crc_match, [1] too_short
);

  logic                   check_mode_q;
  logic                   in_valid_q;
  crc32k_fc_pkg::item_t   in_item_q;
  logic                   out_valid_q;
  crc32k_fc_pkg::result_t out_q;
  crc32k_fc_pkg::result_t core_result;
  logic                   out_free;
  logic                   step;
  logic                   in_take;

  // result slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || m_axis_tready_i;
  // mid-frame bytes need no result slot
  assign step     = in_valid_q && (!in_item_q.frame_end || out_free);
  assign s_axis_tready_o = !in_valid_q || step;
  assign in_take  = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      check_mode_q <= cfg_wdata_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.data_byte <= s_axis_tdata_i;
      in_item_q.frame_end <= s_axis_tlast_i;
    end
  end

  crc32k_fc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .check_mode_i (check_mode_q),
    .item_i       (in_item_q),
    .result_o     (core_result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && in_item_q.frame_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_item_q.frame_end) begin
      out_q <= core_result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.crc_value;
  assign m_axis_tuser_o  = {out_q.too_short, out_q.crc_match};

endmodule

FILE: rtl/crc32k_fc_sva.sv
// port-level assertions for the crc-32k frame checker, bound to the top level
`timescale 1ns / 1ps

module crc32k_fc_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // a too-short frame reports crc 0 and no match
  a_short_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |->
      (m_axis_tdata_o == 32'h0) && !m_axis_tuser_o[0])
    else $error("too-short result carries crc or match");

  // input back-pressure only while a result waits on a stalled receiver
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output back-pressure");

  // no result in the cycle after a reset edge
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

endmodule

bind crc32k_frame_checker crc32k_fc_sva u_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

FILE: sim/tb_crc32k_frame_checker.sv
// self-checking testbench for the crc-32k frame checker
`timescale 1ns / 1ps

module tb_crc32k_frame_checker;

  localparam logic ModeCheck    = 1'b1;
  localparam logic ModeGenerate = 1'b0;
  localparam int   RandomBytes  = 950;
  localparam int   HoldCycles   = 600;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_valid   = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data    = 8'h00;
  logic        s_last    = 1'b0;
  logic        m_valid;
  logic        m_ready   = 1'b0;
  logic [31:0] m_data;
  logic [1:0]  m_user;

  crc32k_frame_checker dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #1 clk = ~clk;

  // byte requests waiting for the driver, crc results waiting for the dut
  crc32k_fc_pkg::item_t    bytes_to_send[$];
  crc32k_fc_pkg::result_t  crc_results_due[$];
  logic [7:0]              frame_buf[$];

  // shadow of the checker state
  logic                             mode_q = ModeCheck;
  logic [31:0]                      shadow_crc = crc32k_fc_pkg::CrcInit;
  logic [7:0]                       shadow_tail[4] = '{8'h00, 8'h00, 8'h00, 8'h00};
  logic [crc32k_fc_pkg::SeenW-1:0]  shadow_seen = '0;

  int   mismatches   = 0;
  int   n_accepted   = 0;
  int   queued_total = 0;
  logic in_fire      = 1'b0;
  logic no_idle      = 1'b0;
  logic stall_hold   = 1'b0;
  int   send_gap     = 0;
  int   ready_gap    = 0;
  crc32k_fc_pkg::item_t next_item;

  // one byte into the low bits, then 32 msb-first polynomial steps
  function automatic logic [31:0] crc_fold(logic [31:0] crc_in, logic [7:0] b);
    logic [31:0] r;
    r = crc_in ^ {24'h0, b};
    for (int k = 0; k < 32; k++) begin
      r = {r[30:0], 1'b0} ^ (crc32k_fc_pkg::CrcPoly & {32{r[31]}});
    end
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 16);
    return $urandom_range(17, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // advance the shadow state by one accepted byte, queue a result on frame end
  task automatic track_byte(input logic [7:0] b, input logic last);
    logic                    had_four;
    logic [31:0]             trailer;
    crc32k_fc_pkg::result_t  res;
    had_four = (shadow_seen >= crc32k_fc_pkg::TailLen);
    if (mode_q == ModeCheck) begin
      // delay line: a byte is covered only once four newer ones arrived
      if (had_four) shadow_crc = crc_fold(shadow_crc, shadow_tail[0]);
      shadow_tail[0] = shadow_tail[1];
      shadow_tail[1] = shadow_tail[2];
      shadow_tail[2] = shadow_tail[3];
      shadow_tail[3] = b;
    end else begin
      shadow_crc = crc_fold(shadow_crc, b);
    end
    if (shadow_seen < crc32k_fc_pkg::MinFrame) shadow_seen = shadow_seen + 1'b1;
    if (last) begin
      res.crc_value = shadow_crc;
      res.crc_match = 1'b0;
      res.too_short = 1'b0;
      if (mode_q == ModeCheck) begin
        if (!had_four) begin
          res.crc_value = 32'h0;
          res.too_short = 1'b1;
        end else begin
          trailer = {shadow_tail[0], shadow_tail[1], shadow_tail[2], shadow_tail[3]};
          res.crc_match = (trailer == shadow_crc);
        end
      end
      crc_results_due.push_back(res);
      shadow_crc  = crc32k_fc_pkg::CrcInit;
      shadow_tail = '{8'h00, 8'h00, 8'h00, 8'h00};
      shadow_seen = '0;
    end
  endtask

  // input acceptance and result checking, sampled before the edge updates
  always @(posedge clk) begin
    if (rst_n) begin
      in_fire = s_valid && s_ready;
      if (m_valid && m_ready) begin
        if (crc_results_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result crc %08h flags %02b", m_data, m_user));
        end else begin
          crc32k_fc_pkg::result_t want;
          want = crc_results_due.pop_front();
          if (m_data !== want.crc_value || m_user[0] !== want.crc_match ||
              m_user[1] !== want.too_short) begin
            report_mismatch($sformatf(
              "crc %08h/%08h match %b/%b too_short %b/%b (got/exp)",
              m_data, want.crc_value, m_user[0], want.crc_match,
              m_user[1], want.too_short));
          end
        end
      end
      if (in_fire) begin
        track_byte(s_data, s_last);
        n_accepted++;
      end
    end
  end

  // byte driver: next request once the current one is taken
  always @(negedge clk) begin
    if (rst_n && (!s_valid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_valid <= 1'b0;
      end else if (bytes_to_send.size() != 0) begin
        next_item = bytes_to_send.pop_front();
        s_valid   <= 1'b1;
        s_data    <= next_item.data_byte;
        s_last    <= next_item.frame_end;
        send_gap  = no_idle ? 0 : pick_gap();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // result sink with random back-pressure
  always @(negedge clk) begin
    if (!rst_n || stall_hold) begin
      m_ready <= 1'b0;
    end else if (no_idle) begin
      m_ready <= 1'b1;
    end else if (ready_gap > 0) begin
      ready_gap--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) ready_gap = pick_gap();
    end
  end

  // one long sink hold-off while the sender keeps offering bytes
  initial begin
    wait (n_accepted >= 400);
    stall_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    stall_hold = 1'b0;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("crc32k_frame_checker regression: fail");
    $finish;
  end

  task automatic push_frame(input bit closed);
    crc32k_fc_pkg::item_t it;
    foreach (frame_buf[i]) begin
      it.data_byte = frame_buf[i];
      it.frame_end = closed && (i == frame_buf.size() - 1);
      bytes_to_send.push_back(it);
      queued_total++;
    end
  endtask

  // big-endian crc of the current buffer appended as a trailer
  task automatic add_crc_trailer();
    logic [31:0] c;
    c = crc32k_fc_pkg::CrcInit;
    foreach (frame_buf[i]) c = crc_fold(c, frame_buf[i]);
    frame_buf.push_back(c[31:24]);
    frame_buf.push_back(c[23:16]);
    frame_buf.push_back(c[15:8]);
    frame_buf.push_back(c[7:0]);
  endtask

  task automatic fill_random(input int n);
    frame_buf.delete();
    for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
  endtask

  task automatic add_random_frame();
    int k;
    int idx;
    k = $urandom_range(0, 99);
    if (mode_q == ModeCheck && k < 65) begin
      fill_random(pick_len());
      add_crc_trailer();
      // some well-formed frames get a single flipped bit
      if (k >= 50) begin
        idx = $urandom_range(0, frame_buf.size() - 1);
        frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else if (mode_q == ModeCheck && k < 80) begin
      fill_random($urandom_range(1, 4));
    end else begin
      fill_random(pick_len());
    end
    push_frame(1'b1);
  endtask

  // all bytes taken, all results back, then room for a byte still in flight
  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || s_valid || crc_results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mode_q    = m;
  endtask

  initial begin
    int stop_at;
    int phase_end;
    int ph;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // check mode out of reset: too short at one and four bytes, then a good frame
    frame_buf = '{8'h00};
    push_frame(1'b1);
    frame_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    push_frame(1'b1);
    frame_buf = '{8'hA5};
    add_crc_trailer();
    push_frame(1'b1);
    wait_idle();

    // generate mode, then a frame left open across a switch to check mode
    set_mode(ModeGenerate);
    frame_buf = '{8'hFF};
    push_frame(1'b1);
    frame_buf = '{8'h00, 8'h7F};
    push_frame(1'b1);
    frame_buf = '{8'h01, 8'hFE};
    push_frame(1'b0);
    wait_idle();
    set_mode(ModeCheck);
    frame_buf = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
    push_frame(1'b1);
    // open frame in check mode, closed in generate mode
    frame_buf = '{8'hC3, 8'h3C, 8'h55};
    push_frame(1'b0);
    wait_idle();
    set_mode(ModeGenerate);
    frame_buf = '{8'hAA};
    push_frame(1'b1);

    // random phases with a fresh mode and idling style each
    stop_at = queued_total + RandomBytes;
    ph = 0;
    while (queued_total < stop_at) begin
      wait_idle();
      set_mode((ph < 2) ? ph[0] : 1'($urandom_range(0, 1)));
      no_idle = ($urandom_range(0, 3) == 0);
      phase_end = queued_total + $urandom_range(60, 160);
      while (queued_total < phase_end && queued_total < stop_at) add_random_frame();
      // sometimes leave a frame open so the next mode picks it up
      if (queued_total < stop_at && $urandom_range(0, 2) == 0) begin
        fill_random($urandom_range(1, 6));
        push_frame(1'b0);
      end
      ph++;
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("crc32k_frame_checker regression: pass");
    end else begin
      $display("crc32k_frame_checker regression: fail");
    end
    $finish;
  end

endmodule
